@@ design/lnw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble writer package
// Types, opcodes and the microcode table of the 4-bit LCD write sequencer.
// ----------------------------------------------------------------------------
package lnw_pkg;

   localparam int PC_W = 5;

   typedef logic [PC_W-1:0] pc_type;
   typedef logic [2:0]      pidx_type;

   // Request kinds.
   localparam logic [1:0] CMD_INSTR  = 2'd0;
   localparam logic [1:0] CMD_DATA   = 2'd1;
   localparam logic [1:0] CMD_NUMBER = 2'd2;
   localparam logic [1:0] CMD_INIT   = 2'd3;

   // Microcode operations.
   localparam logic [3:0] OP_IDLE     = 4'd0;
   localparam logic [3:0] OP_LOAD_VAL = 4'd1;
   localparam logic [3:0] OP_LOAD_IMM = 4'd2;
   localparam logic [3:0] OP_EMIT_HI  = 4'd3;
   localparam logic [3:0] OP_EMIT_LO  = 4'd4;
   localparam logic [3:0] OP_EMIT_LD  = 4'd5;
   localparam logic [3:0] OP_DIG_SUB  = 4'd6;
   localparam logic [3:0] OP_DIG_CHK  = 4'd7;
   localparam logic [3:0] OP_DIG_NEXT = 4'd8;

   // Program entry points.
   localparam pc_type A_IDLE     = 5'd0;
   localparam pc_type A_BYTE     = 5'd1;
   localparam pc_type A_DEC      = 5'd4;
   localparam pc_type A_DEC_NEXT = 5'd8;
   localparam pc_type A_INIT     = 5'd9;

   localparam logic [7:0] DIGIT_BASE = 8'd48;
   localparam pidx_type   PIDX_UNITS = 3'd4;

   typedef struct packed {
      logic [3:0] op;
      logic [7:0] imm;
      logic       last;
      pc_type     nxt;
      pc_type     jmp;
   } ctrl_word_type;

   function automatic ctrl_word_type mk(input logic [3:0] op, input logic [7:0] imm,
                                        input logic last, input pc_type nxt,
                                        input pc_type jmp);
      ctrl_word_type w;
      w.op   = op;
      w.imm  = imm;
      w.last = last;
      w.nxt  = nxt;
      w.jmp  = jmp;
      return w;
   endfunction

   function automatic pc_type entry_of(input logic [1:0] cmd);
      pc_type a;
      case (cmd)
         CMD_INSTR:  a = A_BYTE;
         CMD_DATA:   a = A_BYTE;
         CMD_NUMBER: a = A_DEC;
         CMD_INIT:   a = A_INIT;
         default:    a = A_IDLE;
      endcase
      return a;
   endfunction

   // Decimal weight of each digit position, most significant first.
   function automatic logic [15:0] weight_of(input pidx_type p);
      logic [15:0] w;
      case (p)
         3'd0:    w = 16'd10000;
         3'd1:    w = 16'd1000;
         3'd2:    w = 16'd100;
         3'd3:    w = 16'd10;
         default: w = 16'd1;
      endcase
      return w;
   endfunction

   function automatic ctrl_word_type ucode_rom(input pc_type a);
      ctrl_word_type w;
      case (a)
         // Idle: wait for a request and dispatch on its kind.
         5'd0:  w = mk(OP_IDLE,     8'h00, 1'b0, A_IDLE,     A_IDLE);
         // Single byte.
         5'd1:  w = mk(OP_LOAD_VAL, 8'h00, 1'b0, 5'd2,       A_IDLE);
         5'd2:  w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd3,       A_IDLE);
         5'd3:  w = mk(OP_EMIT_LO,  8'h00, 1'b1, A_IDLE,     A_IDLE);
         // Decimal number, one digit position per pass.
         5'd4:  w = mk(OP_DIG_SUB,  8'h00, 1'b0, 5'd5,       A_DEC);
         5'd5:  w = mk(OP_DIG_CHK,  8'h00, 1'b0, 5'd6,       A_DEC_NEXT);
         5'd6:  w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd7,       A_IDLE);
         5'd7:  w = mk(OP_EMIT_LD,  8'h00, 1'b0, A_DEC_NEXT, A_IDLE);
         5'd8:  w = mk(OP_DIG_NEXT, 8'h00, 1'b0, A_DEC,      A_IDLE);
         // Display set-up sequence.
         5'd9:  w = mk(OP_LOAD_IMM, 8'h02, 1'b0, 5'd10,      A_IDLE);
         5'd10: w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd11,      A_IDLE);
         5'd11: w = mk(OP_EMIT_LO,  8'h00, 1'b0, 5'd12,      A_IDLE);
         5'd12: w = mk(OP_LOAD_IMM, 8'h28, 1'b0, 5'd13,      A_IDLE);
         5'd13: w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd14,      A_IDLE);
         5'd14: w = mk(OP_EMIT_LO,  8'h00, 1'b0, 5'd15,      A_IDLE);
         5'd15: w = mk(OP_LOAD_IMM, 8'h01, 1'b0, 5'd16,      A_IDLE);
         5'd16: w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd17,      A_IDLE);
         5'd17: w = mk(OP_EMIT_LO,  8'h00, 1'b0, 5'd18,      A_IDLE);
         5'd18: w = mk(OP_LOAD_IMM, 8'h0c, 1'b0, 5'd19,      A_IDLE);
         5'd19: w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd20,      A_IDLE);
         5'd20: w = mk(OP_EMIT_LO,  8'h00, 1'b0, 5'd21,      A_IDLE);
         5'd21: w = mk(OP_LOAD_IMM, 8'h06, 1'b0, 5'd22,      A_IDLE);
         5'd22: w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd23,      A_IDLE);
         5'd23: w = mk(OP_EMIT_LO,  8'h00, 1'b0, 5'd24,      A_IDLE);
         5'd24: w = mk(OP_LOAD_IMM, 8'h80, 1'b0, 5'd25,      A_IDLE);
         5'd25: w = mk(OP_EMIT_HI,  8'h00, 1'b0, 5'd26,      A_IDLE);
         5'd26: w = mk(OP_EMIT_LO,  8'h00, 1'b1, A_IDLE,     A_IDLE);
         default: w = mk(OP_IDLE,   8'h00, 1'b0, A_IDLE,     A_IDLE);
      endcase
      return w;
   endfunction

endpackage

@@ design/lcd_nibble_writer_with_decimal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble writer with decimal printing
// Turns byte, number and set-up requests into 4-bit LCD bus transfers,
// driven by a small microcode program.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// req      in         tdata: value[15:0]; tuser: command[1:0]
// rsp      out        tdata: nibble[3:0], zeros[7:4]; tuser: reg_select; tlast: last
//
// One microcode step per cycle unless a stalled result beat holds an emit step; each nibble beat takes one step.
// A byte request runs a load step and two emit steps; set-up runs six load steps, each followed by two emit steps.
// For each of five digit positions, a number runs the repeated-subtraction step once per unit of the digit and once
// more, then a check step and a next step, plus two emit steps per printed digit.
// Reset is synchronous and returns the program counter to idle.
// A stalled result beat holds the sequencer on its emit step.
// ----------------------------------------------------------------------------
module lcd_nibble_writer_with_decimal import lnw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // nibble[3:0], zeros[7:4]
   output logic        rsp_tuser,   // reg_select
   output logic        rsp_tlast
);

   ctrl_word_type word;

   pc_type      pc_ff, pc_in;
   logic [15:0] val_ff, val_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rs_ff, rs_in;
   logic [3:0]  digit_ff, digit_in;
   logic        started_ff, started_in;
   pidx_type    pidx_ff, pidx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_nib_ff, rsp_nib_in;
   logic        rsp_rs_ff, rsp_rs_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic [15:0] weight;

   assign word     = ucode_rom(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign weight   = weight_of(pidx_ff);

   assign req_tready = (word.op == OP_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_nib_ff};
   assign rsp_tuser  = rsp_rs_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      pc_in        = pc_ff;
      val_in       = val_ff;
      byte_in      = byte_ff;
      rs_in        = rs_ff;
      digit_in     = digit_ff;
      started_in   = started_ff;
      pidx_in      = pidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_nib_in   = rsp_nib_ff;
      rsp_rs_in    = rsp_rs_ff;
      rsp_last_in  = rsp_last_ff;

      case (word.op)
         OP_IDLE: begin
            if (req_tvalid) begin
               val_in     = req_tdata;
               rs_in      = req_tuser[0];
               digit_in   = 4'd0;
               started_in = 1'b0;
               pidx_in    = 3'd0;
               pc_in      = entry_of(req_tuser);
            end
         end
         OP_LOAD_VAL: begin
            byte_in = val_ff[7:0];
            pc_in   = word.nxt;
         end
         OP_LOAD_IMM: begin
            byte_in = word.imm;
            rs_in   = 1'b0;
            pc_in   = word.nxt;
         end
         OP_EMIT_HI, OP_EMIT_LO, OP_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rs_in    = rs_ff;
               rsp_nib_in   = (word.op == OP_EMIT_HI) ? byte_ff[7:4] : byte_ff[3:0];
               rsp_last_in  = word.last ||
                              ((word.op == OP_EMIT_LD) && (pidx_ff == PIDX_UNITS));
               pc_in        = word.nxt;
            end
         end
         OP_DIG_SUB: begin
            if (val_ff >= weight) begin
               val_in   = val_ff - weight;
               digit_in = digit_ff + 4'd1;
               pc_in    = word.jmp;
            end else begin
               pc_in    = word.nxt;
            end
         end
         OP_DIG_CHK: begin
            // Leading zeros are dropped, but the units digit is always printed.
            if ((digit_ff == 4'd0) && !started_ff && (pidx_ff != PIDX_UNITS)) begin
               pc_in      = word.jmp;
            end else begin
               byte_in    = DIGIT_BASE + {4'b0000, digit_ff};
               rs_in      = 1'b1;
               started_in = 1'b1;
               pc_in      = word.nxt;
            end
         end
         OP_DIG_NEXT: begin
            if (pidx_ff == PIDX_UNITS) begin
               pc_in    = word.jmp;
            end else begin
               pidx_in  = pidx_ff + 3'd1;
               digit_in = 4'd0;
               pc_in    = word.nxt;
            end
         end
         default: begin
            pc_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= A_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      byte_ff     <= byte_in;
      rs_ff       <= rs_in;
      digit_ff    <= digit_in;
      started_ff  <= started_in;
      pidx_ff     <= pidx_in;
      rsp_nib_ff  <= rsp_nib_in;
      rsp_rs_ff   <= rsp_rs_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble writer testbench
// Sends instruction, data, number and set-up requests on the req stream.
// Every nibble beat on the rsp stream is checked against an expansion of
// the request computed here. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import lnw_pkg::*;

   localparam int RADIX       = 10;
   localparam int QUIET_ITEMS = 60;
   localparam int RANDOM_REQS = 460;
   localparam logic [47:0] SETUP_SEQ = 48'h02_28_01_0c_06_80;

   typedef struct {
      logic [1:0]  command;
      logic [15:0] value;
      bit          wait_drain;
   } lcd_request_type;

   typedef struct {
      logic [3:0] nibble;
      logic       reg_select;
      logic       last;
   } lcd_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // value[15:0]
   logic [1:0]  req_tuser = '0;    // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // nibble[3:0], zeros[7:4]
   logic        rsp_tuser;         // reg_select
   logic        rsp_tlast;

   lcd_request_type requests_pending[$];
   lcd_beat_type    lcd_beats_due[$];
   int              mismatches = 0;
   int              send_gap = 0;
   int              recv_gap = 0;

   lcd_nibble_writer_with_decimal u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // A byte goes out as two beats, high nibble first.
   task automatic push_byte(input logic [7:0] b, input logic rs, input logic is_final);
      lcd_beat_type hi;
      lcd_beat_type lo;
      hi.nibble     = b[7:4];
      hi.reg_select = rs;
      hi.last       = 1'b0;
      lo.nibble     = b[3:0];
      lo.reg_select = rs;
      lo.last       = is_final;
      lcd_beats_due.push_back(hi);
      lcd_beats_due.push_back(lo);
   endtask

   task automatic expand_request(input logic [1:0] command, input logic [15:0] value);
      logic [7:0]  digits [0:4];
      logic [15:0] rest;
      int          count;
      int          k;
      case (command)
         CMD_INSTR: push_byte(value[7:0], 1'b0, 1'b1);
         CMD_DATA:  push_byte(value[7:0], 1'b1, 1'b1);
         CMD_NUMBER: begin
            // Digits are collected least significant first; zero still gives one digit.
            count = 0;
            rest  = value;
            do begin
               digits[count] = DIGIT_BASE + 8'(rest % RADIX);
               rest          = 16'(rest / RADIX);
               count++;
            end while (rest != 0 && count < 5);
            while (count > 0) begin
               count--;
               push_byte(digits[count], 1'b1, count == 0);
            end
         end
         default: begin
            for (k = 0; k < 6; k++)
               push_byte(SETUP_SEQ[47-8*k -: 8], 1'b0, k == 5);
         end
      endcase
   endtask

   task automatic add_request(input logic [1:0] command, input logic [15:0] value,
                              input bit wait_drain);
      lcd_request_type r;
      r.command    = command;
      r.value      = value;
      r.wait_drain = wait_drain;
      requests_pending.push_back(r);
   endtask

   // Request driver: a beat is presented until it is taken, then the next one.
   always @(posedge clock) begin : request_driver
      bit free;
      bit go;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         free = !req_tvalid || req_tready;
         if (req_tvalid && req_tready) begin
            expand_request(req_tuser, req_tdata);
            void'(requests_pending.pop_front());
         end
         if (free) begin
            go = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (requests_pending.size() == 0) begin
               go = 1'b0;
            end else if (requests_pending[0].wait_drain && lcd_beats_due.size() != 0) begin
               go = 1'b0;
            end else if (requests_pending.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 2);
            end else begin
               go = 1'b1;
            end
            req_tvalid <= go;
            if (go) begin
               req_tdata <= requests_pending[0].value;
               req_tuser <= requests_pending[0].command;
            end
         end
      end
   end

   // Result monitor and back-pressure.
   always @(posedge clock) begin : beat_monitor
      lcd_beat_type due;
      bit           rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (lcd_beats_due.size() == 0) begin
               $display("%0t: unexpected beat nibble %h reg_select %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               due = lcd_beats_due.pop_front();
               if (rsp_tdata !== {4'h0, due.nibble}) begin
                  $display("%0t: nibble expected %h actual %h", $time,
                           {4'h0, due.nibble}, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== due.reg_select) begin
                  $display("%0t: reg_select expected %b actual %b", $time,
                           due.reg_select, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== due.last) begin
                  $display("%0t: last expected %b actual %b", $time, due.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         rdy = 1'b1;
         if (recv_gap > 0) begin
            recv_gap--;
            rdy = 1'b0;
         end else if (requests_pending.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 2);
            rdy      = 1'b0;
         end
         rsp_tready <= rdy;
      end
   end

   initial begin : stimulus
      logic [1:0]  command;
      logic [15:0] value;
      int          i;

      // Byte commands, with the upper value bits set to show they are ignored.
      add_request(CMD_INSTR, 16'h0000, 1'b0);
      add_request(CMD_INSTR, 16'h00ff, 1'b0);
      add_request(CMD_INSTR, 16'hff00, 1'b0);
      add_request(CMD_INSTR, 16'ha55a, 1'b0);
      add_request(CMD_DATA,  16'h0041, 1'b0);
      add_request(CMD_DATA,  16'hffff, 1'b0);
      add_request(CMD_DATA,  16'h1200, 1'b0);
      // Numbers: zero prints a single digit, then the digit-count edges.
      add_request(CMD_NUMBER, 16'd0,     1'b0);
      add_request(CMD_NUMBER, 16'd9,     1'b0);
      add_request(CMD_NUMBER, 16'd10,    1'b0);
      add_request(CMD_NUMBER, 16'd100,   1'b0);
      add_request(CMD_NUMBER, 16'd9999,  1'b0);
      add_request(CMD_NUMBER, 16'd10000, 1'b0);
      add_request(CMD_NUMBER, 16'd60000, 1'b0);
      add_request(CMD_NUMBER, 16'd65535, 1'b0);
      // The set-up sequence does not look at the value.
      add_request(CMD_INIT, 16'h0000, 1'b0);
      add_request(CMD_INIT, 16'hffff, 1'b0);
      add_request(CMD_INIT, 16'h1234, 1'b0);

      for (i = 0; i < RANDOM_REQS; i++) begin
         command = 2'($urandom_range(0, 3));
         value   = 16'($urandom_range(0, 65535));
         if (command == CMD_NUMBER) begin
            case ($urandom_range(0, 5))
               0:       value = 16'($urandom_range(0, 9));
               1:       value = 16'($urandom_range(0, 99));
               2:       value = 16'($urandom_range(0, 999));
               3:       value = 16'($urandom_range(0, 9999));
               default: value = 16'($urandom_range(0, 65535));
            endcase
         end
         add_request(command, value, i == 0 || i == RANDOM_REQS / 2);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (requests_pending.size() != 0 || req_tvalid) @(posedge clock);
      while (lcd_beats_due.size() != 0) @(posedge clock);
      // Give stray beats room to show after the last expected beat.
      repeat (100) @(posedge clock);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
